// ----- src/dfsa_pkg.sv -----
// ---------------------------------------------------------------------------
// dfsa_pkg: shared types and constants of the deadline-first slot assigner.
// Holds widths, operation and status codes and the queue cell types.
// ---------------------------------------------------------------------------
`default_nettype none
package dfsa_pkg;

    localparam int MAX_JOBS  = 256;
    localparam int IDX_W     = $clog2(MAX_JOBS);
    localparam int CNT_W     = IDX_W + 1;
    localparam int BKT_DEPTH = MAX_JOBS + 1;
    localparam int BKT_W     = $clog2(BKT_DEPTH);

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_LOAD   = 2'd1,
        OP_ASSIGN = 2'd2,
        OP_UNUSED = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_Q   = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_BAD_POS = 2'd3
    } status_t;

    // Queue key: deadline first, then position, so ties go to the lower position.
    typedef struct packed {
        logic [CNT_W-1:0] deadline;
        logic [CNT_W-1:0] pos;
    } key_t;

    typedef struct packed {
        logic vld;
        key_t key;
    } cell_t;

    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
        key_t key;
    } qcmd_t;

endpackage
`default_nettype wire

// ----- src/dfsa_div.sv -----
// ---------------------------------------------------------------------------
// dfsa_div: restoring divider, one quotient bit per cycle.
// Takes a start pulse and raises done for one cycle with the quotient.
// ---------------------------------------------------------------------------
`default_nettype none
module dfsa_div
    import dfsa_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [CNT_W-1:0] dividend,
    input  wire logic [CNT_W-1:0] divisor,
    output logic                  done,
    output logic [CNT_W-1:0]      quot
);

    localparam int STEP_W = $clog2(CNT_W + 1);

    logic [CNT_W:0]    rem_reg, rem_next, rem_sh;
    logic [CNT_W-1:0]  dq_reg, dq_next;
    logic [CNT_W-1:0]  dvs_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg, done_reg;
    logic              bit_q;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb begin
        rem_sh = {rem_reg[CNT_W-1:0], dq_reg[CNT_W-1]};
        bit_q  = (rem_sh >= {1'b0, dvs_reg});
        rem_next = bit_q ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
        dq_next  = {dq_reg[CNT_W-2:0], bit_q};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            // Done is raised together with the result of the last step.
            done_reg <= busy_reg && !start && (cnt_reg == STEP_W'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= STEP_W'(CNT_W);
                rem_reg  <= '0;
                dq_reg   <= dividend;
                dvs_reg  <= divisor;
            end else if (busy_reg) begin
                rem_reg  <= rem_next;
                dq_reg   <= dq_next;
                cnt_reg  <= cnt_reg - 1'b1;
                busy_reg <= (cnt_reg != STEP_W'(1));
            end
        end
    end

    assign done = done_reg;
    assign quot = dq_reg;

endmodule
`default_nettype wire

// ----- src/dfsa_cell.sv -----
// ---------------------------------------------------------------------------
// dfsa_cell: one cell of the sorted priority queue.
// Keeps one key; on insert it keeps, takes the new key or takes its left
// neighbor; on removal it takes its right neighbor.
// ---------------------------------------------------------------------------
`default_nettype none
module dfsa_cell
    import dfsa_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire qcmd_t cmd,
    input  wire cell_t left,
    input  wire logic  left_lt,
    input  wire cell_t right,
    output cell_t      own,
    output logic       own_lt
);

    cell_t cell_reg;

    // This cell sorts before the incoming key.
    assign own_lt = cell_reg.vld && (cell_reg.key < cmd.key);
    assign own    = cell_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.vld <= 1'b0;
        end else if (cmd.clear) begin
            cell_reg.vld <= 1'b0;
        end else if (cmd.push) begin
            if (!own_lt) begin
                if (left_lt) begin
                    cell_reg.vld <= 1'b1;
                    cell_reg.key <= cmd.key;
                end else begin
                    cell_reg <= left;
                end
            end
        end else if (cmd.pop) begin
            cell_reg <= right;
        end
    end

endmodule
`default_nettype wire

// ----- src/deadline_first_slot_assigner_unit.sv -----
// ---------------------------------------------------------------------------
// deadline_first_slot_assigner_unit: deadline-first slot assigner.
// Files jobs by release slot and hands out slots earliest deadline first.
// ---------------------------------------------------------------------------
// One item is worked at a time. After reset the input is held off
// while a clearing pass empties the bucket and loaded marks. A clear runs
// the same 257-entry clearing pass. An unused op or an assign past the last
// slot goes straight to the result; a rejected load first passes the check
// state, since the loaded mark is read from memory first. A load runs the
// two 9-step divisions of the shared divider, or skips them when the
// quotient is zero. An assign makes, per job released at the new slot, one
// bucket-list read and one insert into the row of queue cells, then one pop.
`default_nettype none
module deadline_first_slot_assigner_unit
    import dfsa_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // position[8:0], quotient[17:9], zeros
    input  wire logic [1:0]  s_tuser,   // op[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // slot[8:0], assigned_position[17:9], zeros
    output logic [1:0]       m_tuser,   // status[1:0]
    output logic             m_tlast,   // done_res
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [8:0]  cfg_data
);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_CLR, S_CHECK, S_DIV_L, S_DIV_R, S_FILE_RD, S_FILE_WR,
        S_BKT_RD, S_BKT, S_JOB_RD, S_PUSH, S_POP, S_OUT
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] job_count_reg;
    logic [CNT_W-1:0] pos_reg, q_reg, l_reg, r_reg, slot_reg;
    logic [IDX_W-1:0] job_reg, cur_j_reg;
    logic [BKT_W-1:0] clr_idx_reg;
    logic [1:0]       res_status_reg;
    logic [CNT_W-1:0] res_slot_reg, res_apos_reg;
    logic             res_done_reg;
    logic             m_tvalid_reg;
    logic [1:0]       m_status_reg;
    logic [CNT_W-1:0] m_slot_reg, m_apos_reg;
    logic             m_done_reg;

    logic             bkt_vld      [BKT_DEPTH];
    logic [IDX_W-1:0] bucket_head  [BKT_DEPTH];
    logic             lnk_vld      [MAX_JOBS];
    logic [IDX_W-1:0] job_link     [MAX_JOBS];
    logic [CNT_W-1:0] job_deadline [MAX_JOBS];
    logic             loaded       [MAX_JOBS];
    logic [IDX_W-1:0] bh_rd, link_rd;
    logic             bv_rd, lv_rd, ld_rd;
    logic [CNT_W-1:0] dl_rd;
    logic [BKT_W-1:0] bh_raddr;

    logic [CNT_W-1:0] in_pos, in_q, n_eff, pos_m1;
    logic [1:0]       in_op;
    logic             accept;
    logic             chk_pos_bad, chk_q_bad;
    logic             clr_we, file_we;
    logic             div_start, div_done;
    logic [CNT_W-1:0] div_dvd, div_dvs, div_quot;

    qcmd_t            qcmd;
    cell_t            cell_q [MAX_JOBS];
    logic             cell_lt [MAX_JOBS];

    assign in_op  = s_tuser;
    assign in_pos = s_tdata[CNT_W-1:0];
    assign in_q   = s_tdata[2*CNT_W-1:CNT_W];
    assign pos_m1 = in_pos - 1'b1;

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Effective job count, held to the range 1 to MAX_JOBS.
    always_comb begin
        if (job_count_reg == '0) begin
            n_eff = CNT_W'(1);
        end else if (job_count_reg > CNT_W'(MAX_JOBS)) begin
            n_eff = CNT_W'(MAX_JOBS);
        end else begin
            n_eff = job_count_reg;
        end
    end

    // Load checks on the latched item, with the loaded mark read at accept.
    assign chk_pos_bad = (pos_reg == '0) || (pos_reg > n_eff) || ld_rd;
    assign chk_q_bad   = (q_reg > pos_reg) || (q_reg == '0 && pos_reg >= n_eff);

    // Divider operands: window start first, then the deadline.
    assign div_start = (state_reg == S_CHECK && !chk_pos_bad && !chk_q_bad && q_reg != '0)
                       || (state_reg == S_DIV_L && div_done);
    assign div_dvd   = pos_reg;
    assign div_dvs   = (state_reg == S_CHECK) ? (q_reg + 1'b1) : q_reg;

    dfsa_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quot     (div_quot)
    );

    // Queue command for the row of cells.
    always_comb begin
        qcmd.clear = accept && in_op == OP_CLEAR;
        qcmd.push  = (state_reg == S_PUSH);
        qcmd.pop   = (state_reg == S_POP) && cell_q[0].vld;
        qcmd.key.deadline = dl_rd;
        qcmd.key.pos      = {1'b0, cur_j_reg} + 1'b1;
    end

    for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
        cell_t left_c, right_c;
        logic  left_lt_c;
        if (i == 0) begin : g_first
            assign left_c    = '0;
            assign left_lt_c = 1'b1;
        end else begin : g_mid
            assign left_c    = cell_q[i-1];
            assign left_lt_c = cell_lt[i-1];
        end
        if (i == MAX_JOBS - 1) begin : g_last
            assign right_c = '0;
        end else begin : g_inner
            assign right_c = cell_q[i+1];
        end
        dfsa_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cmd     (qcmd),
            .left    (left_c),
            .left_lt (left_lt_c),
            .right   (right_c),
            .own     (cell_q[i]),
            .own_lt  (cell_lt[i])
        );
    end

    // Bucket and job memories with registered reads. The clearing pass writes one
    // bucket mark per cycle, and a loaded mark with it for each index below MAX_JOBS.
    assign bh_raddr = (state_reg == S_FILE_RD) ? BKT_W'(l_reg) : BKT_W'(slot_reg);
    assign clr_we   = (state_reg inside {S_INIT, S_CLR});
    assign file_we  = (state_reg == S_FILE_WR);

    always_ff @(posedge aclk) begin
        if (clr_we) begin
            bkt_vld[clr_idx_reg] <= 1'b0;
            if (clr_idx_reg < BKT_W'(MAX_JOBS)) begin
                loaded[clr_idx_reg[IDX_W-1:0]] <= 1'b0;
            end
        end else if (file_we) begin
            // Push the job on the front of its release bucket.
            bucket_head[BKT_W'(l_reg)] <= job_reg;
            bkt_vld[BKT_W'(l_reg)]     <= 1'b1;
            job_link[job_reg]          <= bh_rd;
            lnk_vld[job_reg]           <= bv_rd;
            job_deadline[job_reg]      <= r_reg;
            loaded[job_reg]            <= 1'b1;
        end
        bh_rd   <= bucket_head[bh_raddr];
        bv_rd   <= bkt_vld[bh_raddr];
        link_rd <= job_link[cur_j_reg];
        lv_rd   <= lnk_vld[cur_j_reg];
        dl_rd   <= job_deadline[cur_j_reg];
        ld_rd   <= loaded[pos_m1[IDX_W-1:0]];
    end

    // Control sequencer and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_INIT;
            clr_idx_reg   <= '0;
            job_count_reg <= CNT_W'(1);
            slot_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                job_count_reg <= cfg_data;
            end
            if (m_tvalid_reg && m_tready && state_reg != S_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_INIT, S_CLR: begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                    if (clr_idx_reg == BKT_W'(MAX_JOBS)) begin
                        state_reg <= (state_reg == S_CLR) ? S_OUT : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        pos_reg        <= in_pos;
                        q_reg          <= in_q;
                        job_reg        <= pos_m1[IDX_W-1:0];
                        res_status_reg <= (in_op == OP_ASSIGN && slot_reg >= n_eff)
                                          ? ST_EMPTY : ST_OK;
                        res_slot_reg   <= '0;
                        res_apos_reg   <= '0;
                        res_done_reg   <= 1'b0;
                        case (in_op)
                            OP_CLEAR: begin
                                slot_reg    <= '0;
                                clr_idx_reg <= '0;
                                state_reg   <= S_CLR;
                            end
                            OP_LOAD: begin
                                state_reg <= S_CHECK;
                            end
                            OP_ASSIGN: begin
                                if (slot_reg >= n_eff) begin
                                    state_reg <= S_OUT;
                                end else begin
                                    slot_reg  <= slot_reg + 1'b1;
                                    state_reg <= S_BKT_RD;
                                end
                            end
                            default: begin
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                S_CHECK: begin
                    if (chk_pos_bad) begin
                        res_status_reg <= ST_BAD_POS;
                        state_reg      <= S_OUT;
                    end else if (chk_q_bad) begin
                        res_status_reg <= ST_BAD_Q;
                        state_reg      <= S_OUT;
                    end else if (q_reg == '0) begin
                        l_reg     <= pos_reg + 1'b1;
                        r_reg     <= n_eff;
                        state_reg <= S_FILE_RD;
                    end else begin
                        state_reg <= S_DIV_L;
                    end
                end
                S_DIV_L: begin
                    if (div_done) begin
                        l_reg     <= div_quot + 1'b1;
                        state_reg <= S_DIV_R;
                    end
                end
                S_DIV_R: begin
                    if (div_done) begin
                        r_reg     <= div_quot;
                        state_reg <= S_FILE_RD;
                    end
                end
                S_FILE_RD: begin
                    state_reg <= S_FILE_WR;
                end
                S_FILE_WR: begin
                    state_reg <= S_OUT;
                end
                S_BKT_RD: begin
                    state_reg <= S_BKT;
                end
                S_BKT: begin
                    cur_j_reg <= bh_rd;
                    state_reg <= bv_rd ? S_JOB_RD : S_POP;
                end
                S_JOB_RD: begin
                    state_reg <= S_PUSH;
                end
                S_PUSH: begin
                    // The key goes into the queue; follow the bucket link.
                    cur_j_reg <= link_rd;
                    state_reg <= lv_rd ? S_JOB_RD : S_POP;
                end
                S_POP: begin
                    res_slot_reg <= slot_reg;
                    res_done_reg <= (slot_reg == n_eff);
                    if (cell_q[0].vld) begin
                        res_apos_reg <= cell_q[0].key.pos;
                    end else begin
                        res_status_reg <= ST_EMPTY;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_slot_reg   <= res_slot_reg;
                        m_apos_reg   <= res_apos_reg;
                        m_done_reg   <= res_done_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_done_reg;
    assign m_tdata  = {{(24 - 2*CNT_W){1'b0}}, m_apos_reg, m_slot_reg};

`ifndef SYNTHESIS
    // The queue stays sorted at its head.
    a_head_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        cell_q[1].vld |-> (cell_q[0].vld && cell_q[0].key < cell_q[1].key))
        else $error("queue head out of order");

    // A clear empties the queue.
    a_clear_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_op == OP_CLEAR) |=> !cell_q[0].vld)
        else $error("queue not empty after clear");

    // A pop from a filled queue reports success.
    a_pop_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_POP && cell_q[0].vld) |=> (res_status_reg == ST_OK))
        else $error("pop from filled queue gave a fault status");
`endif

endmodule
`default_nettype wire

// ----- verif/deadline_first_slot_assigner_unit_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Testbench for the deadline-first slot assigner.
// Drives clear, load, assign and unused operations with random pacing, predicts each
// result with a behavioral model of the release buckets and deadline queue,
// and checks every result field against the prediction.
// ---------------------------------------------------------------------------
module deadline_first_slot_assigner_unit_tb;
    import dfsa_pkg::*;

    typedef struct packed {
        op_t        op;
        logic [8:0] position;
        logic [8:0] quotient;
    } job_req_t;

    typedef struct packed {
        status_t    status;
        logic [8:0] slot;
        logic [8:0] apos;
        logic       done;
    } slot_res_t;

    localparam int IDLE_LIMIT = 20000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [8:0]  cfg_data;

    deadline_first_slot_assigner_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // Predictor state.
    int unsigned n_jobs;
    int          bkt_first [0:MAX_JOBS];
    int          next_in_bkt [0:MAX_JOBS-1];
    int unsigned due_slot [0:MAX_JOBS-1];
    bit          is_loaded [0:MAX_JOBS-1];
    int unsigned ready_keys [$];
    int unsigned slot_now;

    job_req_t    pending_reqs [$];
    slot_res_t   expected_res [$];
    int          fail_count;
    bit          calm;
    int          idle_cycles;
    logic        s_tready_seen;

    always begin
        aclk = 1'b1; #5;
        aclk = 1'b0; #5;
    end

    function automatic void clear_model();
        for (int k = 0; k <= MAX_JOBS; k++) bkt_first[k] = -1;
        for (int k = 0; k < MAX_JOBS; k++) is_loaded[k] = 1'b0;
        ready_keys.delete();
        slot_now = 0;
    endfunction

    function automatic int unsigned eff_count();
        if (n_jobs < 1) return 1;
        if (n_jobs > MAX_JOBS) return MAX_JOBS;
        return n_jobs;
    endfunction

    // Work out the result of one accepted item and update the stores.
    function automatic slot_res_t assign_predict(job_req_t r);
        slot_res_t   res;
        int unsigned n, p, q, lo, hi, best;
        int          j;
        n = eff_count();
        p = r.position;
        q = r.quotient;
        res = '0;
        res.status = ST_OK;
        case (r.op)
            OP_CLEAR: clear_model();
            OP_LOAD: begin
                if (p == 0 || p > n || is_loaded[p-1]) begin
                    res.status = ST_BAD_POS;
                end else if (q > p || (q == 0 && p >= n)) begin
                    res.status = ST_BAD_Q;
                end else begin
                    if (q == 0) begin
                        lo = p + 1; hi = n;
                    end else begin
                        lo = p / (q + 1) + 1; hi = p / q;
                    end
                    due_slot[p-1] = hi;
                    next_in_bkt[p-1] = bkt_first[lo];
                    bkt_first[lo] = p - 1;
                    is_loaded[p-1] = 1'b1;
                end
            end
            OP_ASSIGN: begin
                if (slot_now >= n) begin
                    res.status = ST_EMPTY;
                end else begin
                    slot_now++;
                    j = bkt_first[slot_now];
                    while (j >= 0) begin
                        ready_keys.push_back((due_slot[j] << 16) | (j + 1));
                        j = next_in_bkt[j];
                    end
                    res.slot = 9'(slot_now);
                    res.done = (slot_now == n);
                    if (ready_keys.size() == 0) begin
                        res.status = ST_EMPTY;
                    end else begin
                        best = 0;
                        foreach (ready_keys[k])
                            if (ready_keys[k] < ready_keys[best]) best = k;
                        res.apos = 9'(ready_keys[best] & 16'hFFFF);
                        ready_keys.delete(best);
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Driver: presents queued items, idling at random.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready_seen) begin
            if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= 33)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {6'b0, pending_reqs[0].quotient, pending_reqs[0].position};
                s_tuser  <= pending_reqs[0].op;
                void'(pending_reqs.pop_front());
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= calm || ($urandom_range(99) >= 33);
    end

    // Acceptance of the presented item, seen at the rising edge.
    always @(posedge aclk) begin
        s_tready_seen <= s_tvalid && s_tready && aresetn;
        if (aresetn && s_tvalid && s_tready)
            expected_res.push_back(assign_predict(job_req_t'({s_tuser, s_tdata[8:0],
                                                              s_tdata[17:9]})));
    end

    // Monitor: compare each result with the oldest prediction.
    always @(posedge aclk) begin
        slot_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_res.size() == 0) begin
                $error("unexpected result transfer");
                fail_count++;
            end else begin
                want = expected_res.pop_front();
                if (m_tuser != want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_tuser);
                    fail_count++;
                end
                if (m_tdata[8:0] != want.slot) begin
                    $error("slot: expected %0d, actual %0d", want.slot, m_tdata[8:0]);
                    fail_count++;
                end
                if (m_tdata[17:9] != want.apos) begin
                    $error("assigned_position: expected %0d, actual %0d",
                           want.apos, m_tdata[17:9]);
                    fail_count++;
                end
                if (m_tlast != want.done) begin
                    $error("done_res: expected %0d, actual %0d", want.done, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic push_req(op_t op, int unsigned p, int unsigned q);
        job_req_t r;
        r.op = op;
        r.position = 9'(p);
        r.quotient = 9'(q);
        pending_reqs.push_back(r);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || s_tvalid || expected_res.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_job_count(int unsigned v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= 9'(v);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        n_jobs = v & 9'h1FF;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // A problem: every position loaded once, mostly with a random slot's quotient, at times with a random one.
    task automatic queue_problem(int unsigned n);
        int unsigned order [$];
        int unsigned x, p;
        for (int k = 1; k <= n; k++) order.push_back(k);
        order.shuffle();
        push_req(OP_CLEAR, 0, 0);
        foreach (order[k]) begin
            p = order[k];
            x = $urandom_range(n, 1);
            if ($urandom_range(9) == 0)
                push_req(OP_LOAD, p, $urandom_range(511));
            else
                push_req(OP_LOAD, p, p / x);
        end
        for (int k = 0; k < n + 1; k++) begin
            if ($urandom_range(19) == 0)
                push_req(op_t'($urandom_range(3)), $urandom_range(511), $urandom_range(511));
            push_req(OP_ASSIGN, 0, 0);
        end
    endtask

    initial begin
        int unsigned counts [] = '{4, 1, 256, 9, 2, 511, 0, 17, 6, 33};
        int unsigned sent;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_CLEAR;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        fail_count = 0;
        idle_cycles = 0;
        calm = 1'b0;
        n_jobs = 1;
        clear_model();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: field extremes, every op, rejects, late release, step past end.
        write_job_count(4);
        push_req(OP_UNUSED, 511, 511);
        push_req(OP_LOAD, 0, 0);
        push_req(OP_LOAD, 5, 1);
        push_req(OP_LOAD, 2, 3);
        push_req(OP_LOAD, 4, 0);
        push_req(OP_LOAD, 3, 0);
        push_req(OP_LOAD, 3, 1);
        push_req(OP_LOAD, 1, 1);
        push_req(OP_LOAD, 2, 2);
        push_req(OP_LOAD, 4, 2);
        push_req(OP_ASSIGN, 511, 511);
        push_req(OP_ASSIGN, 0, 0);
        push_req(OP_ASSIGN, 0, 0);
        push_req(OP_ASSIGN, 0, 0);
        push_req(OP_ASSIGN, 0, 0);
        push_req(OP_CLEAR, 511, 511);
        push_req(OP_LOAD, 4, 4);
        push_req(OP_ASSIGN, 0, 0);
        push_req(OP_LOAD, 1, 1);
        push_req(OP_ASSIGN, 0, 0);
        wait_drained();

        // Random phases over several job counts, including the extremes.
        // The full-size phase runs with no idling on either side.
        foreach (counts[c]) begin
            write_job_count(counts[c]);
            calm = (counts[c] == 256);
            sent = 0;
            while (sent < 35) begin
                queue_problem(eff_count());
                sent += 2 * eff_count() + 2;
            end
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
